/* src/pcswl_pkg.sv */
// ---------------------------------------------------------------------------
// pcswl_pkg: shared types and constants
// Slot table and ring sizes, sequencer states and the config register indexes.
// ---------------------------------------------------------------------------
package pcswl_pkg;
	localparam int CLIENT_SLOTS = 16;
	localparam int RING_DEPTH   = 64;
	localparam int SLOT_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int ADDR_W  = 32;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 7;
	localparam int WIN_W   = 31;
	localparam int MEM_W   = SLOT_W + POS_W;
	localparam int MEM_DEPTH = CLIENT_SLOTS * RING_DEPTH;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 1'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;
	localparam logic [WIN_W-1:0]   WIN_RESET   = 31'd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MATCH,
		ST_FREE,
		ST_STALE_RD,
		ST_STALE_CHK,
		ST_CLAIM,
		ST_POP_RD,
		ST_POP_CHK,
		ST_DECIDE,
		ST_OUT
	} state_t;

	// age compare shared by the stale scan and the expiry pop
	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] stamp;
		logic [WIN_W-1:0]  window;
	} age_req_t;

	function automatic logic is_old(input age_req_t r);
		logic [TIME_W-1:0] age;
		age = r.now - r.stamp;
		return age > {1'b0, r.window};
	endfunction
endpackage

/* src/pcswl_if.sv */
// ---------------------------------------------------------------------------
// pcswl channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ---------------------------------------------------------------------------
interface pcswl_req_if import pcswl_pkg::*; ();
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] client_address;
	logic [TIME_W-1:0] arrival_time;
	modport source (output valid, client_address, arrival_time, input ready);
	modport sink (input valid, client_address, arrival_time, output ready);
endinterface

interface pcswl_res_if;
	logic valid;
	logic ready;
	logic admitted;
	logic no_slot;
	modport source (output valid, admitted, no_slot, input ready);
	modport sink (input valid, admitted, no_slot, output ready);
endinterface

interface pcswl_cfg_if import pcswl_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/pcswl_ring_mem.sv */
// ---------------------------------------------------------------------------
// pcswl_ring_mem: stamp ring storage
// One write port and one registered read port, all slots' rings in one array.
// ---------------------------------------------------------------------------
module pcswl_ring_mem import pcswl_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [MEM_W-1:0]  waddr,
	input  logic [TIME_W-1:0] wdata,
	input  logic [MEM_W-1:0]  raddr,
	output logic [TIME_W-1:0] rdata
);
	logic [TIME_W-1:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/pcswl_seq.sv */
// ---------------------------------------------------------------------------
// pcswl_seq: slot lookup and expiry sequencer
// Scans the slots in turn, then pops expired stamps through one age compare.
// ---------------------------------------------------------------------------
module pcswl_seq import pcswl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pcswl_req_if.sink  req,
	pcswl_res_if.source res,
	input  logic [LIMIT_W-1:0] request_limit,
	input  logic [WIN_W-1:0]   window_ticks,
	output logic idle
);
	state_t state_q, state_d;

	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic [SLOT_W-1:0] scan_q;
	logic [SLOT_W-1:0] slot_q;
	logic              claim_q;
	logic              admitted_q, no_slot_q;

	logic [ADDR_W-1:0] slot_address [CLIENT_SLOTS];
	logic [CLIENT_SLOTS-1:0] slot_valid_q;
	logic [POS_W-1:0] ring_head_q [CLIENT_SLOTS];
	logic [CNT_W-1:0] ring_count_q [CLIENT_SLOTS];

	logic              mem_we;
	logic [MEM_W-1:0]  mem_waddr, mem_raddr;
	logic [TIME_W-1:0] mem_rdata;
	logic [CNT_W-1:0]  limit_eff;
	logic [POS_W-1:0]  cur_head, newest_pos, tail_pos;
	logic [CNT_W-1:0]  cur_count, scan_count;
	logic              old_hit;
	logic              last_scan;
	age_req_t          age_req;

	pcswl_ring_mem u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(now_q),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign limit_eff = ({{(32-LIMIT_W){1'b0}}, request_limit} < 32'(RING_DEPTH)) ?
		CNT_W'(request_limit) : CNT_W'(RING_DEPTH);
	assign cur_head   = ring_head_q[slot_q];
	assign cur_count  = ring_count_q[slot_q];
	assign scan_count = ring_count_q[scan_q];
	assign newest_pos = POS_W'((32'(ring_head_q[scan_q]) + 32'(scan_count) - 32'd1)
		% RING_DEPTH);
	assign tail_pos   = POS_W'((32'(cur_head) + 32'(cur_count)) % RING_DEPTH);
	assign last_scan  = (32'(scan_q) == CLIENT_SLOTS - 1);

	assign age_req.now    = now_q;
	assign age_req.stamp  = mem_rdata;
	assign age_req.window = window_ticks;
	assign old_hit = is_old(age_req);

	always_comb begin
		mem_raddr = {slot_q, cur_head};
		if (state_q == ST_STALE_RD) begin
			mem_raddr = {scan_q, newest_pos};
		end
	end
	assign mem_we    = (state_q == ST_DECIDE) && (cur_count < limit_eff);
	assign mem_waddr = {slot_q, tail_pos};

	assign req.ready    = (state_q == ST_IDLE);
	assign res.valid    = (state_q == ST_OUT);
	assign res.admitted = admitted_q;
	assign res.no_slot  = no_slot_q;
	assign idle         = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (req.valid) state_d = ST_MATCH;
			ST_MATCH: begin
				if (slot_valid_q[scan_q] && slot_address[scan_q] == addr_q) begin
					state_d = ST_POP_RD;
				end else if (last_scan) begin
					state_d = ST_FREE;
				end
			end
			ST_FREE: begin
				if (!slot_valid_q[scan_q]) state_d = ST_CLAIM;
				else if (last_scan) state_d = ST_STALE_RD;
			end
			ST_STALE_RD: begin
				if (scan_count == '0) state_d = ST_CLAIM;
				else state_d = ST_STALE_CHK;
			end
			ST_STALE_CHK: begin
				if (old_hit) state_d = ST_CLAIM;
				else if (last_scan) state_d = ST_OUT;
				else state_d = ST_STALE_RD;
			end
			ST_CLAIM:     state_d = ST_DECIDE;
			ST_POP_RD: begin
				if (cur_count == '0) state_d = ST_DECIDE;
				else state_d = ST_POP_CHK;
			end
			ST_POP_CHK: begin
				if (old_hit) state_d = ST_POP_RD;
				else state_d = ST_DECIDE;
			end
			ST_DECIDE:    state_d = ST_OUT;
			ST_OUT:       if (res.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// slot table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < CLIENT_SLOTS; i++) begin
				ring_head_q[i]  <= '0;
				ring_count_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_CLAIM) begin
				slot_valid_q[slot_q] <= 1'b1;
				ring_head_q[slot_q]  <= '0;
				ring_count_q[slot_q] <= '0;
			end
			if (state_q == ST_POP_CHK && old_hit) begin
				ring_head_q[slot_q]  <= POS_W'((32'(cur_head) + 32'd1) % RING_DEPTH);
				ring_count_q[slot_q] <= cur_count - CNT_W'(1);
			end
			if (mem_we) begin
				ring_count_q[slot_q] <= cur_count + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLAIM) begin
			slot_address[slot_q] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q <= req.client_address;
				now_q  <= req.arrival_time;
				scan_q <= '0;
			end
			ST_MATCH: begin
				slot_q <= scan_q;
				if (!(slot_valid_q[scan_q] && slot_address[scan_q] == addr_q)) begin
					scan_q <= last_scan ? '0 : scan_q + SLOT_W'(1);
				end
			end
			ST_FREE: begin
				slot_q <= scan_q;
				if (slot_valid_q[scan_q]) scan_q <= last_scan ? '0 : scan_q + SLOT_W'(1);
			end
			ST_STALE_RD: slot_q <= scan_q;
			ST_STALE_CHK: begin
				if (!old_hit) begin
					scan_q <= scan_q + SLOT_W'(1);
					if (last_scan) begin
						admitted_q <= 1'b0;
						no_slot_q  <= 1'b1;
					end
				end
			end
			ST_DECIDE: begin
				admitted_q <= (cur_count < limit_eff);
				no_slot_q  <= 1'b0;
			end
			default: ;
		endcase
	end
endmodule

/* src/per_client_sliding_window_limiter.sv */
// sequence: after acceptance the sequencer compares the slots in turn, reads and checks
//   ring stamps one by one through the single read port, claims a slot if needed and decides
// throughput: one request at a time; the next is accepted only once the result is taken
// the slot scan and the single ring read port set the time each request takes
// reset: slot valid bits, ring heads and counts clear at once; limit 10, window 1000
// ---------------------------------------------------------------------------
// per_client_sliding_window_limiter: top level
// Config registers and the lookup/expiry sequencer.
// ---------------------------------------------------------------------------
module per_client_sliding_window_limiter import pcswl_pkg::*; (
	input logic clk,
	input logic arst_n,
	pcswl_req_if.sink   req,
	pcswl_res_if.source res,
	pcswl_cfg_if.sink   cfg
);
	logic [LIMIT_W-1:0] request_limit_q;
	logic [WIN_W-1:0]   window_ticks_q;
	logic idle;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_limit_q <= LIMIT_RESET;
			window_ticks_q  <= WIN_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_REQUEST_LIMIT) request_limit_q <= cfg.data[LIMIT_W-1:0];
			if (cfg.index == REG_WINDOW_TICKS)  window_ticks_q  <= cfg.data[WIN_W-1:0];
		end
	end

	pcswl_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.res          (res),
		.request_limit(request_limit_q),
		.window_ticks (window_ticks_q),
		.idle         (idle)
	);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !res.valid) else $error("ready while result pending");
	a_res_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !idle) else $error("accepted request lost");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.admitted && res.no_slot)) else $error("admit with no slot");
endmodule

/* sim/limiter_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// limiter_checker: admission predictor and result scoreboard
// Watches the request, result and config channels, keeps its own slot table
// and stamp rings, and compares every result with the predicted verdict.
// ---------------------------------------------------------------------------
module limiter_checker import pcswl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pcswl_req_if req,
	pcswl_res_if res,
	pcswl_cfg_if cfg,
	output int   errors,
	output int   pending
);
	typedef struct packed {
		logic admitted;
		logic no_slot;
	} verdict_t;

	localparam int VQ_DEPTH = 16;

	verdict_t verdicts[VQ_DEPTH];
	int       wr_cnt;
	int       rd_cnt;

	logic [LIMIT_W-1:0] cur_limit;
	logic [WIN_W-1:0]   cur_window;
	logic [ADDR_W-1:0]  owner[CLIENT_SLOTS];
	logic               owned[CLIENT_SLOTS];
	logic [TIME_W-1:0]  stamps[CLIENT_SLOTS][RING_DEPTH];
	int                 oldest[CLIENT_SLOTS];
	int                 held[CLIENT_SLOTS];

	function automatic logic too_old(input logic [TIME_W-1:0] now, stamp);
		logic [TIME_W-1:0] age;
		age = now - stamp;
		return age > {1'b0, cur_window};
	endfunction

	function automatic verdict_t admit_request(input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] now);
		int lim;
		int slot;
		logic hit;
		verdict_t v;
		lim = (cur_limit < RING_DEPTH) ? int'(cur_limit) : RING_DEPTH;
		hit = 1'b0;
		slot = 0;
		for (int s = 0; s < CLIENT_SLOTS; s++)
			if (!hit && owned[s] && owner[s] == addr) begin
				slot = s;
				hit = 1'b1;
			end
		for (int s = 0; s < CLIENT_SLOTS; s++)
			if (!hit && !owned[s]) begin
				slot = s;
				hit = 1'b1;
			end
		// stale: empty ring or newest stamp outside the window
		for (int s = 0; s < CLIENT_SLOTS; s++)
			if (!hit && (held[s] == 0 ||
					too_old(now, stamps[s][(oldest[s] + held[s] - 1) % RING_DEPTH]))) begin
				slot = s;
				hit = 1'b1;
			end
		v = '0;
		if (!hit) begin
			v.no_slot = 1'b1;
			return v;
		end
		if (!owned[slot] || owner[slot] != addr) begin
			owned[slot] = 1'b1;
			owner[slot] = addr;
			oldest[slot] = 0;
			held[slot] = 0;
		end
		while (held[slot] > 0 && too_old(now, stamps[slot][oldest[slot]])) begin
			oldest[slot] = (oldest[slot] + 1) % RING_DEPTH;
			held[slot]--;
		end
		if (held[slot] >= lim)
			return v;
		stamps[slot][(oldest[slot] + held[slot]) % RING_DEPTH] = now;
		held[slot]++;
		v.admitted = 1'b1;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			cur_limit <= LIMIT_RESET;
			cur_window <= WIN_RESET;
			for (int s = 0; s < CLIENT_SLOTS; s++) begin
				owned[s] = 1'b0;
				oldest[s] = 0;
				held[s] = 0;
			end
			wr_cnt <= 0;
			rd_cnt <= 0;
			errors <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (rd_cnt == wr_cnt) begin
					$display("%0t: result with nothing expected: admitted %b no_slot %b",
						$time, res.admitted, res.no_slot);
					errors <= errors + 1;
				end else begin
					want = verdicts[rd_cnt % VQ_DEPTH];
					rd_cnt <= rd_cnt + 1;
					if (want.admitted !== res.admitted || want.no_slot !== res.no_slot) begin
						$display("%0t: mismatch: expected admitted %b no_slot %b, got %b %b",
							$time, want.admitted, want.no_slot, res.admitted, res.no_slot);
						errors <= errors + 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				verdicts[wr_cnt % VQ_DEPTH] <= admit_request(req.client_address,
					req.arrival_time);
				wr_cnt <= wr_cnt + 1;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_REQUEST_LIMIT: cur_limit <= cfg.data[LIMIT_W-1:0];
					REG_WINDOW_TICKS: cur_window <= cfg.data[WIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign pending = wr_cnt - rd_cnt;
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: per-client sliding window limiter
// Drives directed and random requests over several limit and window settings
// with random idling on both sides; the checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench import pcswl_pkg::*;;
	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   send_idle;
	int   recv_idle;
	int   sent;
	logic [TIME_W-1:0] now;
	logic [ADDR_W-1:0] pool[24];

	pcswl_req_if req();
	pcswl_res_if res();
	pcswl_cfg_if cfg();

	per_client_sliding_window_limiter i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source), .cfg(cfg.sink)
	);

	limiter_checker i_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** per_client_sliding_window_limiter: FAILED **");
		$finish;
	end

	always @(posedge clk)
		res.ready <= ($urandom_range(99) >= recv_idle);

	task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] t);
		logic hs;
		if ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.client_address <= addr;
		req.arrival_time <= t;
		do begin
			@(negedge clk);
			hs = req.ready;
			@(posedge clk);
		end while (!hs);
		sent++;
		// idling follows the position in the run
		if (sent < 230) begin
			send_idle = 14;
			recv_idle = 72;
		end else if (sent < 460) begin
			send_idle = 72;
			recv_idle = 14;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	// drain, let the sequencer settle, then write a register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		logic hs;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do begin
			@(negedge clk);
			hs = cfg.ready;
			@(posedge clk);
		end while (!hs);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(input int n, input int step);
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80)
				a = pool[$urandom_range(0, 23)];
			else
				a = $urandom;
			if ($urandom_range(99) < 4)
				now = $urandom;
			else if ($urandom_range(99) < 30)
				now = now;
			else
				now = now + $urandom_range(0, step);
			send_request(a, now);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.client_address = '0;
		req.arrival_time = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_REQUEST_LIMIT;
		cfg.data = '0;
		send_idle = 14;
		recv_idle = 72;
		sent = 0;
		for (int i = 0; i < 24; i++) pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, wrap of the tick count
		send_request('0, '0);
		send_request('1, '1);
		send_request('1, 32'd999);
		send_request('1, 32'd1000);
		send_request(32'h5555_5555, 32'hAAAA_AAAA);
		// fill every slot within the window, then one more client gets no slot
		for (int i = 0; i < 15; i++) send_request(32'h0A00_0000 + i, 32'd1005);
		send_request(32'hC0A8_0001, 32'd1006);
		// later on every slot is stale and the new client claims the lowest one
		send_request(32'hC0A8_0001, 32'd3000);
		// zero limit denies but still claims
		write_reg(REG_REQUEST_LIMIT, 32'd0);
		send_request(32'h7F00_0001, 32'd3001);
		send_request(32'h7F00_0001, 32'd3001);
		// upper data bits are masked: limit 127 (so 64), window 0
		write_reg(REG_REQUEST_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_WINDOW_TICKS, 32'h8000_0000);
		send_request(32'h7F00_0001, 32'd3001);
		send_request(32'h7F00_0001, 32'd3001);
		send_request(32'h7F00_0001, 32'd3002);

		// random: limit above ring depth, hammer one instant
		now = 32'd5000;
		for (int i = 0; i < 70; i++) send_request(pool[0], now);
		write_reg(REG_WINDOW_TICKS, 32'h7FFF_FFFF);
		random_phase(60, 3);
		write_reg(REG_REQUEST_LIMIT, 32'd3);
		write_reg(REG_WINDOW_TICKS, 32'd50);
		now = 32'hFFFF_FE00;
		random_phase(110, 12);
		write_reg(REG_REQUEST_LIMIT, 32'd64);
		write_reg(REG_WINDOW_TICKS, 32'd2000);
		random_phase(100, 60);
		write_reg(REG_REQUEST_LIMIT, 32'd1);
		write_reg(REG_WINDOW_TICKS, 32'd0);
		random_phase(90, 2);
		write_reg(REG_REQUEST_LIMIT, 32'd5);
		write_reg(REG_WINDOW_TICKS, 32'd300);
		random_phase(130, 40);
		write_reg(REG_REQUEST_LIMIT, 32'd10);
		write_reg(REG_WINDOW_TICKS, 32'd1000);
		random_phase(90, 150);
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("** per_client_sliding_window_limiter: PASSED **");
		else
			$display("** per_client_sliding_window_limiter: FAILED **");
		$finish;
	end
endmodule

/* per_client_sliding_window_limiter.f */
src/pcswl_pkg.sv
src/pcswl_if.sv
src/pcswl_ring_mem.sv
src/pcswl_seq.sv
src/per_client_sliding_window_limiter.sv
sim/limiter_checker.sv
sim/testbench.sv
